[rtl/core/kwm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kwm_pkg
// Types and constants shared by the keyword matcher modules.
// ----------------------------------------------------------------------------
package kwm_pkg;

    localparam int ALPHABET_LETTERS = 52;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_END  = 2'd1;
    localparam logic [1:0] OP_SCAN = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BADBYTE = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    localparam logic MODE_TRIE = 1'b0;
    localparam logic MODE_DEAD = 1'b1;

    localparam logic [7:0] CHAR_LC_A = 8'h61;
    localparam logic [7:0] CHAR_LC_Z = 8'h7a;
    localparam logic [7:0] CHAR_UC_A = 8'h41;
    localparam logic [7:0] CHAR_UC_Z = 8'h5a;
    localparam logic [7:0] CHAR_SPC  = 8'h20;
    localparam logic [5:0] UC_OFFSET = 6'd26;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] char_code;
        logic       last_char;
    } t_in;

    typedef struct packed {
        logic [1:0] status;
        logic       match_found;
        logic [7:0] keyword_node;
    } t_out;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_CLOSE
    } t_state;

    typedef struct packed {
        logic clr;
        logic accept;
        logic exec;
        logic close;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic out_free;
        logic need_close;
    } t_sts;

endpackage
`default_nettype wire

[rtl/core/whole_word_keyword_matcher_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// whole_word_keyword_matcher_unit
// Trie keyword loader and whole-word text scanner.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid/o_in_ready, i_in_data) carries one opcode with a
// byte: load keyword letter, end keyword, or scan text byte. Output channel
// (o_out_valid/i_out_ready, o_out_data) returns one result per input
// transaction: status, match flag and the end node of the matched keyword.
// After reset the child table and word-end flags are swept to zero, one
// entry per cycle, across all TRIE_NODES*52 child slots; no input is taken
// during the sweep.
// Each item is accepted, then executed; a scanned letter marked last_char
// adds a closing-space step (extra word-end flag read for the implied
// space) that loads the result. The child table read is registered at
// accept, ahead of the trie step; no new item is taken until these finish.
// A stalled receiver holds the result register; the next item is still
// accepted and waits in its execute step until the result register frees.
// ----------------------------------------------------------------------------
module whole_word_keyword_matcher_unit #(
    parameter int TRIE_NODES = 256
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire kwm_pkg::t_in  i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output kwm_pkg::t_out      o_out_data
);
    import kwm_pkg::*;

    t_cmd cmd;
    t_sts sts;

    kwm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    kwm_dpath #(
        .TRIE_NODES (TRIE_NODES)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire

[rtl/core/kwm_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kwm_ctrl
// Sequencer: table clearing sweep, accept, execute and closing-space steps.
// ----------------------------------------------------------------------------
module kwm_ctrl (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_ready,
    input  wire kwm_pkg::t_sts i_sts,
    output kwm_pkg::t_cmd     o_cmd
);
    import kwm_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = i_sts.need_close ? S_CLOSE : S_IDLE;
                end
            end
            S_CLOSE: begin
                if (i_sts.out_free) begin
                    o_cmd.close = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule
`default_nettype wire

[rtl/core/kwm_dpath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kwm_dpath
// Trie child table, word-end flags, load and scan cursors, result register.
// ----------------------------------------------------------------------------
module kwm_dpath #(
    parameter int TRIE_NODES = 256
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire kwm_pkg::t_cmd i_cmd,
    output kwm_pkg::t_sts      o_sts,
    input  wire kwm_pkg::t_in  i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output kwm_pkg::t_out      o_out_data
);
    import kwm_pkg::*;

    localparam int NW    = $clog2(TRIE_NODES);
    localparam int DEPTH = TRIE_NODES * ALPHABET_LETTERS;
    localparam int AW    = $clog2(DEPTH);

    logic [NW-1:0] child_mem [DEPTH];
    logic          flag_mem  [TRIE_NODES];

    logic [AW-1:0] r_clr_cnt;
    logic [1:0]    r_op;
    logic          r_is_letter;
    logic          r_is_space;
    logic          r_last;
    logic [AW-1:0] r_slot;
    logic [NW-1:0] r_child_rd;
    logic          r_flag_rd;
    logic [NW:0]   r_nodes_used;
    logic [NW:0]   n_nodes_used;
    logic [NW-1:0] r_load_cursor;
    logic [NW-1:0] n_load_cursor;
    logic [NW-1:0] r_scan_node;
    logic [NW-1:0] n_scan_node;
    logic          r_scan_mode;
    logic          n_scan_mode;
    logic          r_out_valid;
    t_out          r_out;

    // input decode
    logic          in_lc;
    logic          in_uc;
    logic [5:0]    in_li;
    logic [NW-1:0] rd_node;
    logic [AW-1:0] rd_slot;

    // execute results
    logic          child_we;
    logic          flag_we;
    logic          flag_re;
    logic [NW-1:0] flag_raddr;
    logic [1:0]    res_status;
    logic          res_match;
    logic [NW-1:0] res_node;
    logic          out_load;

    assign in_lc = (i_in_data.char_code >= CHAR_LC_A) && (i_in_data.char_code <= CHAR_LC_Z);
    assign in_uc = (i_in_data.char_code >= CHAR_UC_A) && (i_in_data.char_code <= CHAR_UC_Z);
    assign in_li = in_lc ? 6'(i_in_data.char_code - CHAR_LC_A)
                         : 6'(i_in_data.char_code - CHAR_UC_A) + UC_OFFSET;
    assign rd_node = (i_in_data.opcode == OP_LOAD) ? r_load_cursor : r_scan_node;
    assign rd_slot = AW'(AW'(rd_node) * AW'(ALPHABET_LETTERS)) + AW'(in_li);

    assign o_sts.clr_last   = (r_clr_cnt == AW'(DEPTH - 1));
    assign o_sts.out_free   = !r_out_valid || i_out_ready;
    assign o_sts.need_close = (r_op == OP_SCAN) && r_is_letter && r_last;

    assign flag_re    = i_cmd.accept || (i_cmd.exec && o_sts.need_close);
    assign flag_raddr = i_cmd.accept ? r_scan_node : n_scan_node;
    assign out_load   = (i_cmd.exec && !o_sts.need_close) || i_cmd.close;

    always_comb begin
        n_load_cursor = r_load_cursor;
        n_nodes_used  = r_nodes_used;
        n_scan_node   = r_scan_node;
        n_scan_mode   = r_scan_mode;
        child_we      = 1'b0;
        flag_we       = 1'b0;
        res_status    = ST_OK;
        res_match     = 1'b0;
        res_node      = '0;
        if (i_cmd.exec) begin
            unique case (r_op)
                OP_LOAD: begin
                    if (!r_is_letter) begin
                        res_status = ST_BADBYTE;
                    end else if (r_child_rd != '0) begin
                        n_load_cursor = r_child_rd;
                    end else if (r_nodes_used >= (NW+1)'(TRIE_NODES)) begin
                        res_status = ST_FULL;
                    end else begin
                        child_we      = 1'b1;
                        n_load_cursor = r_nodes_used[NW-1:0];
                        n_nodes_used  = r_nodes_used + 1'b1;
                    end
                end
                OP_END: begin
                    flag_we       = (r_load_cursor != '0);
                    n_load_cursor = '0;
                end
                OP_SCAN: begin
                    if (r_is_space) begin
                        res_match   = (r_scan_mode == MODE_TRIE) && r_flag_rd;
                        res_node    = res_match ? r_scan_node : '0;
                        n_scan_node = '0;
                        n_scan_mode = MODE_TRIE;
                    end else if (!r_is_letter) begin
                        res_status = ST_BADBYTE;
                    end else if (r_scan_mode == MODE_TRIE) begin
                        if (r_child_rd == '0) begin
                            n_scan_mode = MODE_DEAD;
                            n_scan_node = '0;
                        end else begin
                            n_scan_node = r_child_rd;
                        end
                    end
                end
                default: begin
                end
            endcase
        end else if (i_cmd.close) begin
            res_match   = (r_scan_mode == MODE_TRIE) && r_flag_rd;
            res_node    = res_match ? r_scan_node : '0;
            n_scan_node = '0;
            n_scan_mode = MODE_TRIE;
        end
    end

    // child table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            child_mem[r_clr_cnt] <= '0;
        end else if (child_we) begin
            child_mem[r_slot] <= r_nodes_used[NW-1:0];
        end
        if (i_cmd.accept) begin
            r_child_rd <= child_mem[rd_slot];
        end
    end

    // word-end flags
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr && (r_clr_cnt < AW'(TRIE_NODES))) begin
            flag_mem[r_clr_cnt[NW-1:0]] <= 1'b0;
        end else if (flag_we) begin
            flag_mem[r_load_cursor] <= 1'b1;
        end
        if (flag_re) begin
            r_flag_rd <= flag_mem[flag_raddr];
        end
    end

    // item fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op        <= i_in_data.opcode;
            r_is_letter <= in_lc || in_uc;
            r_is_space  <= (i_in_data.char_code == CHAR_SPC);
            r_last      <= i_in_data.last_char;
            r_slot      <= rd_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt     <= '0;
            r_nodes_used  <= (NW+1)'(1);
            r_load_cursor <= '0;
            r_scan_node   <= '0;
            r_scan_mode   <= MODE_TRIE;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cmd.clr) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            r_nodes_used  <= n_nodes_used;
            r_load_cursor <= n_load_cursor;
            r_scan_node   <= n_scan_node;
            r_scan_mode   <= n_scan_mode;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.status       <= res_status;
            r_out.match_found  <= res_match;
            r_out.keyword_node <= 8'(res_node);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_nodes_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_nodes_used != '0) && (r_nodes_used <= (NW+1)'(TRIE_NODES)))
        else $error("node count out of range");

    a_cursor_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (NW+1)'(r_load_cursor) < r_nodes_used)
        else $error("load cursor points at an unallocated node");

    a_dead_at_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_scan_mode == MODE_DEAD) |-> (r_scan_node == '0))
        else $error("dead scan mode away from start node");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> o_sts.out_free)
        else $error("result register overwritten before transaction");

endmodule
`default_nettype wire

[bench/tb_whole_word_keyword_matcher_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_whole_word_keyword_matcher_unit
// Self-checking bench for the trie keyword loader and whole-word scanner.
// A short table of directed transactions (empty table, bad bytes, unused
// opcode, empty keyword, matches by space and by last letter) is followed by
// random keyword loads, scanned sentences built from the loaded keywords,
// noise, and a pass that fills the node table. Every accepted transaction
// runs through a local trie model; results are compared in order, with
// random gaps on the sender and random stalls on the receiver.
// ----------------------------------------------------------------------------
module tb_whole_word_keyword_matcher_unit;
    import kwm_pkg::*;

    localparam int TRIE_NODES     = 256;
    localparam int WATCHDOG_LIMIT = 50000;
    localparam int TAIL_CYCLES    = 20;
    localparam int VOCAB_MAX      = 64;
    localparam int WORD_MAX       = 12;
    localparam int DIRECTED_ROWS  = 26;
    localparam logic [1:0] OP_NONE = 2'd3;

    typedef struct packed {
        logic typed;
        t_out value;
    } known_t;

    typedef struct packed {
        t_in  item;
        logic typed;
        t_out value;
    } row_t;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  in_valid = 1'b0;
    t_in   in_data = '0;
    logic  in_ready;
    logic  out_valid;
    logic  out_ready = 1'b0;
    t_out  out_data;

    whole_word_keyword_matcher_unit #(
        .TRIE_NODES(TRIE_NODES)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    // trie model state
    logic [7:0] kids [TRIE_NODES*ALPHABET_LETTERS];
    logic       word_end [TRIE_NODES];
    logic [8:0] nodes_used;
    logic [7:0] load_cursor;
    logic [7:0] scan_node;
    logic       scan_mode;

    t_out   expected_results [$];
    known_t known_q [$];
    int     mismatches = 0;
    int     sent = 0;
    int     idle_cycles = 0;
    logic   calm = 1'b0;

    logic [7:0] vocab_chars [VOCAB_MAX][WORD_MAX];
    int         vocab_len [VOCAB_MAX];
    int         vocab_count = 0;
    logic [7:0] wbuf [WORD_MAX+1];
    int         wlen;

    row_t directed_rows [DIRECTED_ROWS] = '{
        {OP_SCAN, CHAR_SPC,  1'b0, 1'b1, ST_OK,      1'b0, 8'd0},
        {OP_SCAN, CHAR_LC_A, 1'b1, 1'b1, ST_OK,      1'b0, 8'd0},
        {OP_LOAD, 8'h00,     1'b0, 1'b1, ST_BADBYTE, 1'b0, 8'd0},
        {OP_LOAD, CHAR_SPC,  1'b1, 1'b1, ST_BADBYTE, 1'b0, 8'd0},
        {OP_LOAD, 8'hFF,     1'b0, 1'b1, ST_BADBYTE, 1'b0, 8'd0},
        {OP_SCAN, 8'h7B,     1'b0, 1'b1, ST_BADBYTE, 1'b0, 8'd0},
        {OP_SCAN, 8'h40,     1'b1, 1'b1, ST_BADBYTE, 1'b0, 8'd0},
        {OP_NONE, 8'hFF,     1'b1, 1'b1, ST_OK,      1'b0, 8'd0},
        {OP_END,  8'h00,     1'b0, 1'b1, ST_OK,      1'b0, 8'd0},
        {OP_LOAD, CHAR_LC_A, 1'b0, 1'b0, ST_OK,      1'b0, 8'd0},
        {OP_LOAD, CHAR_LC_Z, 1'b0, 1'b0, ST_OK,      1'b0, 8'd0},
        {OP_END,  8'h00,     1'b0, 1'b0, ST_OK,      1'b0, 8'd0},
        {OP_LOAD, CHAR_UC_A, 1'b0, 1'b0, ST_OK,      1'b0, 8'd0},
        {OP_LOAD, CHAR_UC_Z, 1'b0, 1'b0, ST_OK,      1'b0, 8'd0},
        {OP_END,  8'h00,     1'b0, 1'b0, ST_OK,      1'b0, 8'd0},
        {OP_SCAN, CHAR_LC_A, 1'b0, 1'b0, ST_OK,      1'b0, 8'd0},
        {OP_SCAN, CHAR_LC_Z, 1'b0, 1'b0, ST_OK,      1'b0, 8'd0},
        {OP_SCAN, CHAR_SPC,  1'b0, 1'b1, ST_OK,      1'b1, 8'd2},
        {OP_SCAN, CHAR_UC_A, 1'b0, 1'b0, ST_OK,      1'b0, 8'd0},
        {OP_SCAN, CHAR_UC_Z, 1'b1, 1'b1, ST_OK,      1'b1, 8'd4},
        {OP_SCAN, CHAR_LC_A, 1'b0, 1'b0, ST_OK,      1'b0, 8'd0},
        {OP_SCAN, 8'h80,     1'b1, 1'b1, ST_BADBYTE, 1'b0, 8'd0},
        {OP_SCAN, CHAR_LC_Z, 1'b0, 1'b0, ST_OK,      1'b0, 8'd0},
        {OP_SCAN, CHAR_SPC,  1'b1, 1'b1, ST_OK,      1'b1, 8'd2},
        {OP_SCAN, CHAR_LC_Z, 1'b0, 1'b0, ST_OK,      1'b0, 8'd0},
        {OP_SCAN, CHAR_LC_A, 1'b1, 1'b1, ST_OK,      1'b0, 8'd0}
    };

    initial begin
        for (int i = 0; i < TRIE_NODES*ALPHABET_LETTERS; i++) kids[i] = 8'd0;
        for (int i = 0; i < TRIE_NODES; i++) word_end[i] = 1'b0;
        nodes_used  = 9'd1;
        load_cursor = 8'd0;
        scan_node   = 8'd0;
        scan_mode   = MODE_TRIE;
    end

    function automatic int letter_of(logic [7:0] c);
        if (c >= CHAR_LC_A && c <= CHAR_LC_Z) return int'(c - CHAR_LC_A);
        if (c >= CHAR_UC_A && c <= CHAR_UC_Z) return int'(c - CHAR_UC_A) + 26;
        return -1;
    endfunction

    function automatic t_out closed_word(t_out r);
        if (scan_mode == MODE_TRIE && word_end[scan_node]) begin
            r.match_found  = 1'b1;
            r.keyword_node = scan_node;
        end
        scan_node = 8'd0;
        scan_mode = MODE_TRIE;
        return r;
    endfunction

    function automatic t_out trie_step(t_in it);
        t_out       r;
        int         li;
        int         s;
        logic [7:0] nxt;
        r  = '0;
        li = letter_of(it.char_code);
        case (it.opcode)
            OP_LOAD: begin
                if (li < 0) begin
                    r.status = ST_BADBYTE;
                end else begin
                    s = int'(load_cursor) * ALPHABET_LETTERS + li;
                    if (kids[s] != 8'd0) begin
                        load_cursor = kids[s];
                    end else if (nodes_used >= TRIE_NODES) begin
                        r.status = ST_FULL;
                    end else begin
                        kids[s]     = nodes_used[7:0];
                        load_cursor = nodes_used[7:0];
                        nodes_used  = nodes_used + 9'd1;
                    end
                end
            end
            OP_END: begin
                if (load_cursor != 8'd0) word_end[load_cursor] = 1'b1;
                load_cursor = 8'd0;
            end
            OP_SCAN: begin
                if (it.char_code == CHAR_SPC) begin
                    r = closed_word(r);
                end else if (li < 0) begin
                    r.status = ST_BADBYTE;
                end else begin
                    if (scan_mode == MODE_TRIE) begin
                        nxt = kids[int'(scan_node) * ALPHABET_LETTERS + li];
                        if (nxt == 8'd0) begin
                            scan_mode = MODE_DEAD;
                            scan_node = 8'd0;
                        end else begin
                            scan_node = nxt;
                        end
                    end
                    if (it.last_char) r = closed_word(r);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] rand_letter(logic wide);
        int n;
        if (wide || $urandom_range(0, 4) == 0) begin
            n = $urandom_range(0, 51);
            return (n < 26) ? CHAR_LC_A + 8'(n) : CHAR_UC_A + 8'(n - 26);
        end
        case ($urandom_range(0, 3))
            0: return CHAR_LC_A;
            1: return CHAR_LC_A + 8'd1;
            2: return CHAR_LC_A + 8'd2;
            default: return CHAR_UC_A;
        endcase
    endfunction

    task automatic send(input t_in it, input logic typed, input t_out value);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        known_q.push_back({typed, value});
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent++;
        @(negedge clk);
    endtask

    task automatic put(input logic [1:0] op, input logic [7:0] ch, input logic last);
        send({op, ch, last}, 1'b0, '0);
    endtask

    task automatic noise_item();
        put(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    task automatic load_keyword(input logic wide, input int max_len);
        int         len;
        int         idx;
        logic [7:0] ch;
        len = $urandom_range(1, max_len);
        idx = (vocab_count < VOCAB_MAX) ? vocab_count : $urandom_range(0, VOCAB_MAX - 1);
        for (int j = 0; j < len; j++) begin
            if (!wide && $urandom_range(0, 19) == 0) put(OP_LOAD, 8'($urandom_range(0, 255)), 1'b0);
            ch = rand_letter(wide);
            vocab_chars[idx][j] = ch;
            put(OP_LOAD, ch, 1'($urandom_range(0, 1)));
        end
        vocab_len[idx] = len;
        if (vocab_count < VOCAB_MAX) vocab_count++;
        // a missing end keeps the cursor, so the next keyword grows this one
        if ($urandom_range(0, 19) != 0) put(OP_END, 8'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic build_word();
        int k;
        int r;
        r = $urandom_range(0, 9);
        if (vocab_count == 0 || r >= 8) begin
            wlen = $urandom_range(1, 4);
            for (int j = 0; j < wlen; j++) wbuf[j] = rand_letter(1'b0);
            return;
        end
        k    = $urandom_range(0, vocab_count - 1);
        wlen = vocab_len[k];
        for (int j = 0; j < wlen; j++) wbuf[j] = vocab_chars[k][j];
        if (r == 6 && wlen > 1) wlen = $urandom_range(1, wlen - 1);
        if (r == 7) begin
            wbuf[wlen] = rand_letter(1'b0);
            wlen++;
        end
    endtask

    task automatic scan_text();
        int   nwords;
        int   tail;
        logic last;
        nwords = $urandom_range(1, 4);
        tail   = $urandom_range(0, 2);
        for (int i = 0; i < nwords; i++) begin
            build_word();
            for (int j = 0; j < wlen; j++) begin
                if ($urandom_range(0, 29) == 0) noise_item();
                last = (i == nwords - 1) && (j == wlen - 1) && (tail == 0);
                put(OP_SCAN, wbuf[j], last);
            end
            if (i < nwords - 1) begin
                put(OP_SCAN, CHAR_SPC, 1'b0);
                if ($urandom_range(0, 7) == 0) put(OP_SCAN, CHAR_SPC, 1'b0);
            end
        end
        if (tail != 0) put(OP_SCAN, CHAR_SPC, tail == 1);
    endtask

    initial begin
        int g;
        forever begin
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(negedge clk);
            g = pick_gap();
            if (g > 0) begin
                out_ready <= 1'b0;
                repeat (g) @(negedge clk);
            end
        end
    end

    known_t note;
    t_out   want;
    t_out   predicted;

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d match %0d node %0d",
                             out_data.status, out_data.match_found, out_data.keyword_node);
            end else begin
                want = expected_results.pop_front();
                if (out_data.status !== want.status ||
                    out_data.match_found !== want.match_found ||
                    out_data.keyword_node !== want.keyword_node) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected status %0d match %0d node %0d, got %0d %0d %0d",
                                 want.status, want.match_found, want.keyword_node,
                                 out_data.status, out_data.match_found, out_data.keyword_node);
                end
            end
        end
        if (rst_n && in_valid && in_ready) begin
            note      = known_q.pop_front();
            predicted = trie_step(in_data);
            expected_results.push_back(note.typed ? note.value : predicted);
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++)
            send(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].value);

        // mixed loads, sentences and noise over a small alphabet
        while (sent < 380) begin
            if ($urandom_range(0, 11) == 0) calm = ~calm;
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5: load_keyword(1'b0, 5);
                6, 7, 8:          noise_item();
                default:          scan_text();
            endcase
        end
        calm = 1'b0;

        // fill the node table and run into the full case
        while (nodes_used < TRIE_NODES) load_keyword(1'b1, WORD_MAX);
        repeat (4) load_keyword(1'b1, WORD_MAX);

        while (sent < 800) begin
            if ($urandom_range(0, 11) == 0) calm = ~calm;
            case ($urandom_range(0, 19))
                0:       load_keyword(1'b0, 5);
                1, 2:    noise_item();
                default: scan_text();
            endcase
        end

        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
